### hdl/sde_pkg.sv
// sde_pkg: shared types, round constants and sigma functions for the SHA-256 engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sde_pkg;

   localparam int WORD_W   = 32;
   localparam int ROUNDS   = 64;
   localparam int BLK_WORDS = 16;
   localparam int LEN_W    = 61;

   localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;

   typedef logic [7:0][WORD_W-1:0] word_arr_type;

   localparam word_arr_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   typedef struct packed {
      logic [WORD_W-1:0] data_word;
      logic [2:0]        valid_bytes;
      logic              last;
   } sde_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_word;
      logic [2:0]        word_index;
      logic              last_word;
   } sde_rsp_type;

   typedef struct packed {
      logic push;     // shift a message word into the window
      logic expand;   // shift an expanded schedule word into the window
   } sched_ctl_type;

   typedef struct packed {
      logic load;     // copy chain value into the working variables
      logic step;     // run one compression round
   } round_ctl_type;

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int n);
      rotr = (v >> n) | (v << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] big_s0(input logic [WORD_W-1:0] v);
      big_s0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic logic [WORD_W-1:0] big_s1(input logic [WORD_W-1:0] v);
      big_s1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic logic [WORD_W-1:0] small_s0(input logic [WORD_W-1:0] v);
      small_s0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_s1(input logic [WORD_W-1:0] v);
      small_s1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

   function automatic logic [WORD_W-1:0] round_k(input logic [5:0] t);
      logic [WORD_W-1:0] k;
      case (t)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
      endcase
      round_k = k;
   endfunction

endpackage

### hdl/sha256_digest_engine.sv
// SHA-256 digest engine, top level: sequencer, chain value, padding and digest output.
// Depends on sde_pkg, sde_sched and sde_round.
`timescale 1ns / 1ps

// Message words are taken one per cycle while the engine is idle. The 16th word of a
// block starts 64 rounds on the single round unit (one round per cycle), then the fold
// state adds the result into the chain value. After the last word the pad, zero fill and
// length words are pushed one per cycle and compressed the same way (one or two more
// blocks), then the eight digest words leave through a registered output, one per beat
// taken. req_ready is low from the 16th word of a block, or the last word, until the
// engine is idle again.
module sha256_digest_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sde_pkg::sde_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sde_pkg::sde_rsp_type rsp_data
);
   import sde_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROUND = 5'b00010,
      ST_FOLD  = 5'b00100,
      ST_PAD   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   word_arr_type     chain_ff, chain_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic [3:0]       slot_ff, slot_in;
   logic [5:0]       round_ff, round_in;
   logic [3:0]       out_cnt_ff, out_cnt_in;
   logic [63:0]      len_ff, len_in;
   logic             mark_ff, mark_in;    // 0x80 word still owed
   logic             hi_ff, hi_in;        // upper length word pushed
   logic             final_ff, final_in;  // block in flight is the last one
   logic             pad_ff, pad_in;      // padding in progress
   logic             rsp_valid_ff, rsp_valid_in;
   sde_rsp_type      rsp_data_ff, rsp_data_in;

   sched_ctl_type    sched_ctl;
   round_ctl_type    round_ctl;
   logic [WORD_W-1:0] push_word, wt;
   word_arr_type      vars;

   logic             req_acc;
   logic [2:0]       nsat;
   logic [WORD_W-1:0] tail_word;
   logic [LEN_W-1:0] total_sum;

   sde_sched u_sched (
      .clock     (clock),
      .ctl       (sched_ctl),
      .push_word (push_word),
      .wt        (wt)
   );

   sde_round u_round (
      .clock (clock),
      .ctl   (round_ctl),
      .chain (chain_ff),
      .kt    (round_k(round_ff)),
      .wt    (wt),
      .vars  (vars)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign nsat = (req_data.valid_bytes > 3'd4) ? 3'd4 : req_data.valid_bytes;

   // keep the valid bytes of a short last word and place the pad byte right after them
   always_comb begin
      case (nsat[1:0])
         2'd0:    tail_word = PAD_WORD;
         2'd1:    tail_word = {req_data.data_word[31:24], 8'h80, 16'h0000};
         2'd2:    tail_word = {req_data.data_word[31:16], 8'h80, 8'h00};
         default: tail_word = {req_data.data_word[31:8], 8'h80};
      endcase
   end

   assign total_sum = total_ff + (req_data.last ? LEN_W'(nsat) : LEN_W'(4));

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      total_in     = total_ff;
      slot_in      = slot_ff;
      round_in     = round_ff;
      out_cnt_in   = out_cnt_ff;
      len_in       = len_ff;
      mark_in      = mark_ff;
      hi_in        = hi_ff;
      final_in     = final_ff;
      pad_in       = pad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      sched_ctl    = '0;
      round_ctl    = '0;
      push_word    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               sched_ctl.push = 1'b1;
               total_in       = total_sum;
               if (!req_data.last || nsat == 3'd4) begin
                  push_word = req_data.data_word;
               end else begin
                  push_word = tail_word;
               end
               if (req_data.last) begin
                  len_in   = {total_sum, 3'b000};
                  mark_in  = (nsat == 3'd4);
                  hi_in    = 1'b0;
                  pad_in   = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            sched_ctl.push = 1'b1;
            if (mark_ff) begin
               push_word = PAD_WORD;
               mark_in   = 1'b0;
            end else if (slot_ff == 4'd14) begin
               push_word = len_ff[63:32];
               hi_in     = 1'b1;
            end else if (slot_ff == 4'd15 && hi_ff) begin
               push_word = len_ff[31:0];
               final_in  = 1'b1;
            end
         end
         ST_ROUND: begin
            round_ctl.step   = 1'b1;
            sched_ctl.expand = 1'b1;
            round_in         = round_ff + 6'd1;
            if (round_ff == 6'(ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + vars[i];
            end
            out_cnt_in = '0;
            if (final_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.digest_word = chain_ff[out_cnt_ff[2:0]];
               rsp_data_in.word_index  = out_cnt_ff[2:0];
               rsp_data_in.last_word   = (out_cnt_ff[2:0] == 3'd7);
               out_cnt_in              = out_cnt_ff + 4'd1;
               if (out_cnt_ff[2:0] == 3'd7) begin
                  chain_in = INIT_HASH;
                  total_in = '0;
                  final_in = 1'b0;
                  pad_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a push into the last slot closes the block and starts compression
      if (sched_ctl.push) begin
         slot_in = slot_ff + 4'd1;
         if (slot_ff == 4'(BLK_WORDS - 1)) begin
            round_ctl.load = 1'b1;
            round_in       = '0;
            state_in       = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff     <= INIT_HASH;
         total_ff     <= '0;
         slot_ff      <= '0;
         round_ff     <= '0;
         out_cnt_ff   <= '0;
         mark_ff      <= 1'b0;
         hi_ff        <= 1'b0;
         final_ff     <= 1'b0;
         pad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         total_ff     <= total_in;
         slot_ff      <= slot_in;
         round_ff     <= round_in;
         out_cnt_ff   <= out_cnt_in;
         mark_ff      <= mark_in;
         hi_ff        <= hi_in;
         final_ff     <= final_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### hdl/sde_sched.sv
// sde_sched: 16-word message schedule window, shifted once per pushed or expanded word.
// Depends on sde_pkg.
`timescale 1ns / 1ps

module sde_sched (
   input  logic                  clock,
   input  sde_pkg::sched_ctl_type ctl,
   input  logic [31:0]           push_word,
   output logic [31:0]           wt
);
   import sde_pkg::*;

   logic [BLK_WORDS-1:0][WORD_W-1:0] w_ff, w_in;
   logic [WORD_W-1:0]                next_w;

   // window holds W[t..t+15]; tap 0 is the word for the current round
   assign next_w = small_s1(w_ff[14]) + w_ff[9] + small_s0(w_ff[1]) + w_ff[0];
   assign wt     = w_ff[0];

   always_comb begin
      w_in = w_ff;
      if (ctl.push || ctl.expand) begin
         for (int i = 0; i < BLK_WORDS - 1; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[BLK_WORDS-1] = ctl.push ? push_word : next_w;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

endmodule

### hdl/sde_round.sv
// sde_round: working variables a..h and the shared SHA-256 round datapath.
// Depends on sde_pkg.
`timescale 1ns / 1ps

module sde_round (
   input  logic                  clock,
   input  sde_pkg::round_ctl_type ctl,
   input  sde_pkg::word_arr_type  chain,
   input  logic [31:0]           kt,
   input  logic [31:0]           wt,
   output sde_pkg::word_arr_type  vars
);
   import sde_pkg::*;

   word_arr_type      v_ff, v_in;
   logic [WORD_W-1:0] t1, t2, ch, maj;

   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + big_s1(v_ff[4]) + ch + kt + wt;
   assign t2  = big_s0(v_ff[0]) + maj;
   assign vars = v_ff;

   always_comb begin
      v_in = v_ff;
      if (ctl.load) begin
         v_in = chain;
      end else if (ctl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

endmodule

### hdl/sde_checker.sv
// sde_checker: port-level assertions for the SHA-256 engine, bound to the top level.
// Depends on sde_pkg and sha256_digest_engine.
`timescale 1ns / 1ps

module sde_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input sde_pkg::sde_req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input sde_pkg::sde_rsp_type rsp_data
);
   import sde_pkg::*;

   // result beat holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   // final flag only on the eighth digest word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == 3'd7)))
      else $error("last_word does not match word_index");

   // digest words leave in order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_word ##1 rsp_valid
      |-> rsp_data.word_index == $past(rsp_data.word_index) + 3'd1)
      else $error("digest word out of order");

   // the last word starts padding, so no beat can follow at once
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last |=> !req_ready)
      else $error("req accepted right after the last word");

endmodule

bind sha256_digest_engine sde_checker u_sde_checker (.*);

### dv/sde_digest_checker.sv
// sde_digest_checker: watches both channels of the SHA-256 engine, predicts digests, compares.
// Depends on sde_pkg for the beat types; the hash math is computed locally.
`timescale 1ns / 1ps

module sde_digest_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  sde_pkg::sde_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sde_pkg::sde_rsp_type rsp_data,
   output int                   fail_count,
   output int                   digests_due,
   output int                   words_checked
);

   typedef logic [7:0][31:0]  chain_t;
   typedef logic [15:0][31:0] block_t;

   localparam logic [31:0] PAD_BYTE_WORD = 32'h8000_0000;

   localparam logic [31:0] HASH_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   chain_t               chain;
   block_t               blk_words;
   logic [3:0]           blk_fill;
   logic [60:0]          msg_len;
   sde_pkg::sde_rsp_type digest_q [$];
   sde_pkg::sde_rsp_type want;
   int                   errors = 0;
   int                   checked = 0;

   function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
      logic [63:0] twice;
      twice = {v, v} >> n;
      return twice[31:0];
   endfunction

   function automatic logic [31:0] ep0(input logic [31:0] v);
      return ror32(v, 2) ^ ror32(v, 13) ^ ror32(v, 22);
   endfunction

   function automatic logic [31:0] ep1(input logic [31:0] v);
      return ror32(v, 6) ^ ror32(v, 11) ^ ror32(v, 25);
   endfunction

   function automatic logic [31:0] sg0(input logic [31:0] v);
      return ror32(v, 7) ^ ror32(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] sg1(input logic [31:0] v);
      return ror32(v, 17) ^ ror32(v, 19) ^ (v >> 10);
   endfunction

   function automatic chain_t run_rounds(input chain_t cv, input block_t blk);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      chain_t      nxt;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++)
         w[i] = sg1(w[i-2]) + w[i-7] + sg0(w[i-15]) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = cv[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + ep1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = ep0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int j = 7; j > 0; j--) v[j] = v[j-1];
         v[4] = v[4] + t1;   // v[4] now holds old d + t1, the new e
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) nxt[i] = cv[i] + v[i];
      return nxt;
   endfunction

   task automatic restart_message();
      for (int i = 0; i < 8; i++) chain[i] = HASH_IV[i];
      msg_len = '0;
      blk_fill = '0;
   endtask

   task automatic absorb(input logic [31:0] w);
      blk_words[blk_fill] = w;
      blk_fill = blk_fill + 1'b1;
      if (blk_fill == 4'd0) chain = run_rounds(chain, blk_words);
   endtask

   // last beat: pad, length, then queue the eight digest words
   task automatic close_message(input logic [31:0] data, input logic [2:0] vb);
      logic [2:0]           n;
      logic [31:0]          keep;
      logic [63:0]          bit_len;
      sde_pkg::sde_rsp_type d;
      n = (vb > 3'd4) ? 3'd4 : vb;
      msg_len = msg_len + n;
      if (n == 3'd4) begin
         absorb(data);
         absorb(PAD_BYTE_WORD);
      end else begin
         keep = ~(32'hFFFF_FFFF >> (8 * n));
         absorb((data & keep) | (32'h80 << (24 - 8 * n)));
      end
      while (blk_fill != 4'd14) absorb(32'h0);
      bit_len = {msg_len, 3'b000};
      absorb(bit_len[63:32]);
      absorb(bit_len[31:0]);
      for (int k = 0; k < 8; k++) begin
         d.digest_word = chain[k];
         d.word_index  = k[2:0];
         d.last_word   = (k == 7);
         digest_q.push_back(d);
      end
      restart_message();
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
      if (errors < 40)
         $display("%0t ns mismatch: %s got %h expected %h", $time, what, got, exp_v);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         digest_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.last) begin
               close_message(req_data.data_word, req_data.valid_bytes);
            end else begin
               msg_len = msg_len + 61'd4;
               absorb(req_data.data_word);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               report("digest beat with none pending, word", rsp_data.digest_word, 32'h0);
            end else begin
               want = digest_q.pop_front();
               if (rsp_data.digest_word !== want.digest_word)
                  report("digest_word", rsp_data.digest_word, want.digest_word);
               if (rsp_data.word_index !== want.word_index)
                  report("word_index", 32'(rsp_data.word_index), 32'(want.word_index));
               if (rsp_data.last_word !== want.last_word)
                  report("last_word", 32'(rsp_data.last_word), 32'(want.last_word));
               checked++;
            end
         end
      end
      fail_count    <= errors;
      digests_due   <= digest_q.size();
      words_checked <= checked;
   end

endmodule

### dv/tb.sv
// tb: stimulus and verdict for sha256_digest_engine; directed messages, then random ones.
// Depends on sde_pkg, the engine RTL and sde_digest_checker.
`timescale 1ns / 1ps

module tb;
   import sde_pkg::*;

   typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_kind_type;

   localparam int STALL_LIMIT = 3000;
   localparam int WORD_TARGET = 170;
   localparam int QUIET_AFTER = 140;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sde_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sde_rsp_type rsp_data;

   int fail_count, digests_due, words_checked;
   int words_sent = 0;
   int msgs_sent = 0;
   int idle_cycles = 0;
   int ready_hold = 0;
   bit quiet = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sha256_digest_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sde_digest_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .digests_due   (digests_due),
      .words_checked (words_checked)
   );

   // digest side: runs of ready broken by stall bursts, always ready once quiet
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_ready  <= 1'b1;
            ready_hold <= quiet ? 0 : $urandom_range(1, 40);
         end else begin
            rsp_ready  <= 1'b0;
            ready_hold <= $urandom_range(1, 16);
         end
      end else begin
         ready_hold <= ready_hold - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
         $display("[sha256_digest_engine] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_beat(input sde_req_type beat, input bit gappy);
      int gap;
      if (gappy && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic send_message(input int n_full, input logic [2:0] tail_bytes,
                               input logic [31:0] tail_data, input fill_kind_type fill,
                               input bit gappy);
      sde_req_type beat;
      for (int i = 0; i < n_full; i++) begin
         case (fill)
            FILL_ZEROS: beat.data_word = 32'h0;
            FILL_ONES:  beat.data_word = 32'hFFFF_FFFF;
            default:    beat.data_word = $urandom;
         endcase
         beat.valid_bytes = 3'($urandom_range(0, 7));   // ignored on non-last words
         beat.last        = 1'b0;
         send_beat(beat, gappy);
      end
      beat.data_word   = tail_data;
      beat.valid_bytes = tail_bytes;
      beat.last        = 1'b1;
      send_beat(beat, gappy);
      msgs_sent++;
   endtask

   initial begin
      int n_full;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message with junk in the data word
      send_message(0, 3'd0, 32'hFFFF_FFFF, FILL_RANDOM, 1'b0);
      // byte count above four saturates
      send_message(0, 3'd7, 32'h0000_0000, FILL_RANDOM, 1'b1);
      send_message(0, 3'd3, 32'hFFFF_FFFF, FILL_RANDOM, 1'b0);
      send_message(1, 3'd1, 32'h0000_0000, FILL_ONES, 1'b1);
      // full last word followed by pad spills the length into a second block
      send_message(13, 3'd4, 32'hFFFF_FFFF, FILL_ZEROS, 1'b0);

      while (words_sent < WORD_TARGET) begin
         if (words_sent >= QUIET_AFTER) quiet <= 1'b1;
         n_full = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 50) : $urandom_range(0, 20);
         // keep the total close to the target word count
         if (n_full > WORD_TARGET - words_sent - 1) n_full = WORD_TARGET - words_sent - 1;
         send_message(n_full, 3'($urandom_range(0, 7)), $urandom, FILL_RANDOM,
                      (words_sent < QUIET_AFTER) && $urandom_range(0, 2) != 0);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (digests_due != 0);
      repeat (20) @(posedge clock);

      $display("Run covered %0d message words over %0d messages (empty, partial and",
               words_sent, msgs_sent);
      $display("multi-block), with %0d digest words compared.", words_checked);
      if (fail_count == 0) begin
         $display("[sha256_digest_engine] OK");
      end else begin
         $display("[sha256_digest_engine] ERROR");
      end
      $finish;
   end

endmodule
